### src/mhir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Magnetometer hard-iron RLS package
// Shared types, constants and fixed-point helpers for the calibration block.
// ----------------------------------------------------------------------------
package mhir_pkg;

  localparam int FRAC_BITS_DEF   = 24;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FF_FRAC         = 24;
  localparam int FF_W            = 25;

  localparam logic [FF_W-1:0] FF_RESET = 25'd16760439;
  localparam logic [63:0]     COV_INIT = 64'd5000000000;

  localparam logic signed [63:0] I64_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] I64_MIN  = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] BIAS_LIM = 64'sh0000_0100_0000_0000;
  localparam logic signed [63:0] U32_MAX  = 64'sh0000_0000_FFFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_TAKE,
    ST_ISSUE,
    ST_WAIT,
    ST_OUT
  } st_e;

  typedef enum logic [3:0] {
    OP_PX,
    OP_D,
    OP_K,
    OP_E,
    OP_UPD,
    OP_CM,
    OP_CD,
    OP_BSQ,
    OP_DONE
  } op_e;

  typedef struct packed {
    logic start;
    logic div;
  } alu_req_t;

  // Clip a 128-bit value to the signed 64-bit range.
  function automatic logic [63:0] sat64(input logic [127:0] a);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &a[127:63];
    hi_zeros = ~|a[127:63];
    if (hi_ones || hi_zeros) begin
      return a[63:0];
    end
    return a[127] ? I64_MIN : I64_MAX;
  endfunction

  // Lower-triangle slot of covariance entry (r, c); the pair is mirrored
  // into the lower triangle when c > r.
  function automatic logic [3:0] cidx(input logic [1:0] r, input logic [1:0] c);
    logic [3:0] base;
    logic [1:0] hi;
    logic [1:0] lo;
    hi = (c > r) ? c : r;
    lo = (c > r) ? r : c;
    case (hi)
      2'd0:    base = 4'd0;
      2'd1:    base = 4'd1;
      2'd2:    base = 4'd3;
      default: base = 4'd6;
    endcase
    return base + {2'b00, lo};
  endfunction

  function automatic logic [63:0] cov_init(input int frac);
    logic [127:0] t;
    t = 128'(COV_INIT) << frac;
    return sat64(t);
  endfunction

endpackage

### src/mhir_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Magnetometer hard-iron RLS arithmetic unit
// Shared shift-add multiplier (128 x 64, saturating) and restoring divider
// (128 / 128, truncating, saturating to 64 bits). One bit per cycle.
// ----------------------------------------------------------------------------
module mhir_alu (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mhir_pkg::alu_req_t    req_i,
  input  logic signed [127:0]   a_i,
  input  logic signed [127:0]   b_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic signed [127:0]   res_o
);

  logic         busy_q, fin_q, done_q, div_q;
  logic [6:0]   cnt_q;
  logic [6:0]   last;
  logic [127:0] ma_q;
  logic [63:0]  mb_q;
  logic [191:0] acc_q;
  logic [127:0] qn_q;
  logic         neg_q, dz_q, nz_q, nsg_q;
  logic [127:0] res_q;

  logic [127:0] mag_a, mag_b;
  logic [63:0]  mag_b64;
  logic [127:0] trial;
  logic         ge;
  logic [127:0] mul_res, div_res;
  logic         ovf, big;
  logic [63:0]  q64;

  assign last = div_q ? 7'd127 : 7'd63;

  always_comb begin
    mag_a   = a_i[127] ? 128'(-a_i) : a_i;
    mag_b   = b_i[127] ? 128'(-b_i) : b_i;
    mag_b64 = b_i[63] ? (64'd0 - b_i[63:0]) : b_i[63:0];
    trial   = {acc_q[126:0], qn_q[127]};
    ge      = trial >= ma_q;
  end

  always_comb begin
    ovf = |acc_q[191:127];
    if (ovf) begin
      mul_res = neg_q ? {1'b1, 127'd0} : {1'b0, {127{1'b1}}};
    end else begin
      mul_res = neg_q ? (128'd0 - acc_q[127:0]) : acc_q[127:0];
    end
    big = |qn_q[127:63];
    if (dz_q) begin
      q64 = nz_q ? (nsg_q ? mhir_pkg::I64_MIN : mhir_pkg::I64_MAX) : 64'd0;
    end else if (neg_q) begin
      q64 = big ? mhir_pkg::I64_MIN : (64'd0 - qn_q[63:0]);
    end else begin
      q64 = big ? mhir_pkg::I64_MAX : qn_q[63:0];
    end
    div_res = 128'($signed(q64));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      div_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        div_q  <= req_i.div;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == last) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      if (req_i.div) begin
        ma_q  <= mag_b;
        qn_q  <= mag_a;
        neg_q <= a_i[127] ^ b_i[127];
        dz_q  <= (b_i == '0);
        nz_q  <= (a_i != '0);
        nsg_q <= a_i[127];
      end else begin
        ma_q  <= mag_a;
        mb_q  <= mag_b64;
        neg_q <= a_i[127] ^ b_i[63];
      end
    end else if (busy_q) begin
      if (div_q) begin
        acc_q[127:0] <= ge ? (trial - ma_q) : trial;
        qn_q         <= {qn_q[126:0], ge};
      end else begin
        acc_q <= (acc_q << 1) + (mb_q[63] ? 192'(ma_q) : 192'd0);
        mb_q  <= mb_q << 1;
      end
    end else if (fin_q) begin
      res_q <= div_q ? div_res : mul_res;
    end
  end

  assign busy_o = busy_q | fin_q;
  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q && !fin_q)
    else $error("alu started while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("alu done held longer than one cycle");
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !req_i.start && cnt_q == last |=> fin_q)
    else $error("alu missed its finishing cycle");
`endif

endmodule

### src/magnetometer_hard_iron_rls.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Magnetometer hard-iron RLS calibration
// Estimates the hard-iron bias of a three-axis magnetometer by recursive
// least squares with a forgetting factor and returns the corrected sample.
// ----------------------------------------------------------------------------
// channel  | dir | signals                           | beat
// s_axis   | in  | tvalid, tready, tdata[47:0]       | one raw sample
// m_axis   | out | tvalid, tready, tdata, tuser[0]   | corrected sample + estimate
// cfg      | in  | cfg_we_i, cfg_wdata_i[24:0]       | forgetting factor, Q1.24
//
// An accepted sample runs 35 multiplies and 14 divides, all on one shared
// bit-serial arithmetic unit; a rejected sample skips them and goes straight
// to the output. s_axis_tready is high only while idle.
// A finished beat waits in the output register; the next sample is taken
// meanwhile. Reset loads the estimate and covariance at once, no sweep.
// ----------------------------------------------------------------------------
module magnetometer_hard_iron_rls #(
  parameter int FRAC_BITS   = mhir_pkg::FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = mhir_pkg::SAMPLE_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // mag_x[15:0], mag_y[31:16], mag_z[47:32]
  input  logic [47:0]   s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // cal_x[16:0], cal_y[33:17], cal_z[50:34], bias_out_x[66:51],
  // bias_out_y[82:67], bias_out_z[98:83], field_sq[130:99], zero pad
  output logic [135:0]  m_axis_tdata,
  // accepted[0]
  output logic [0:0]    m_axis_tuser,
  input  logic          cfg_we_i,
  input  logic [24:0]   cfg_wdata_i
);

  localparam int SB  = SAMPLE_BITS;
  localparam int DW  = 2 * SB + 4;
  localparam int LSH = (FRAC_BITS >= mhir_pkg::FF_FRAC) ? FRAC_BITS - mhir_pkg::FF_FRAC : 0;
  localparam int RSH = (FRAC_BITS >= mhir_pkg::FF_FRAC) ? 0 : mhir_pkg::FF_FRAC - FRAC_BITS;
  localparam logic [63:0] COV_RST = mhir_pkg::cov_init(FRAC_BITS);

  mhir_pkg::st_e state_q, state_d;
  mhir_pkg::op_e op_q, op_d;
  logic [1:0] ri_q, ri_d, ci_q, ci_d, ax_q, ax_d;

  logic [24:0]              ff_q;
  logic signed [SB-1:0]     v_q [3];
  logic signed [SB-1:0]     last_q [3];
  logic [DW-1:0]            dist_q, vsq_q;
  logic                     take_q;
  logic signed [63:0]       cov_q [10];
  logic signed [63:0]       bias_q [3];
  logic signed [63:0]       off_q, bsq_q, fld_q;
  logic signed [127:0]      acc_q, d_q;
  logic signed [127:0]      px_q [4];
  logic signed [63:0]       k_q [4];
  logic signed [63:0]       e_q, t_q;
  logic                     m_valid_q, m_user_q;
  logic [130:0]             m_data_q;

  mhir_pkg::alu_req_t       alu_req;
  logic signed [127:0]      alu_a, alu_b, alu_res;
  logic                     alu_busy, alu_done;

  logic [63:0]              lam;
  logic [3:0]               cov_ix, cov_rd_ix;
  logic signed [63:0]       cov_rd;
  logic signed [SB-1:0]     v_in [3];
  logic signed [SB:0]       dif;
  logic signed [2*SB+1:0]   dsq, vsq1;
  logic                     take;
  logic                     in_acc, wb_en, out_load;
  logic signed [127:0]      p_sar, px_sum, d_sum, e_sum, upd_sum, bsq_sum;
  logic signed [63:0]       bsq_new;
  logic [130:0]             out_data;

  assign lam       = (64'(ff_q) << LSH) >> RSH;
  assign cov_ix    = mhir_pkg::cidx(ri_q, ci_q);
  assign cov_rd_ix = (op_q == mhir_pkg::OP_PX && state_q == mhir_pkg::ST_WAIT) ?
                     4'd6 + {2'b00, ri_q} : cov_ix;
  assign cov_rd    = cov_q[cov_rd_ix];
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign wb_en     = (state_q == mhir_pkg::ST_WAIT) && alu_done;
  assign out_load  = (state_q == mhir_pkg::ST_OUT) && (!m_valid_q || m_axis_tready);

  // Low SAMPLE_BITS of each zero-extended field, taken as signed.
  always_comb begin
    logic [23:0] z;
    for (int i = 0; i < 3; i++) begin
      z       = {8'd0, s_axis_tdata[16*i +: 16]};
      v_in[i] = $signed(z[SB-1:0]);
    end
  end

  always_comb begin
    logic signed [127:0] lhs_a, lhs_b, d5;
    dif   = (SB+1)'(last_q[ax_q]) - (SB+1)'(v_q[ax_q]);
    dsq   = (2*SB+2)'(dif) * (2*SB+2)'(dif);
    vsq1  = (2*SB+2)'(v_q[ax_q]) * (2*SB+2)'(v_q[ax_q]);
    d5    = (128'(dist_q) << 2) + 128'(dist_q);
    lhs_a = 128'(bsq_q) <<< 1;
    lhs_b = d5 <<< FRAC_BITS;
    take  = (lhs_a > 128'(fld_q)) || (lhs_b > (128'(fld_q) <<< 1));
  end

  // Next state and step sequencer.
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    ri_d    = ri_q;
    ci_d    = ci_q;
    ax_d    = ax_q;
    case (state_q)
      mhir_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = mhir_pkg::ST_PREP;
          ax_d    = 2'd0;
        end
      end
      mhir_pkg::ST_PREP: begin
        if (ax_q == 2'd2) begin
          state_d = mhir_pkg::ST_TAKE;
        end else begin
          ax_d = ax_q + 2'd1;
        end
      end
      mhir_pkg::ST_TAKE: begin
        op_d = mhir_pkg::OP_PX;
        ri_d = 2'd0;
        ci_d = 2'd0;
        state_d = take ? mhir_pkg::ST_ISSUE : mhir_pkg::ST_OUT;
      end
      mhir_pkg::ST_ISSUE: begin
        state_d = (op_q == mhir_pkg::OP_DONE) ? mhir_pkg::ST_OUT : mhir_pkg::ST_WAIT;
      end
      mhir_pkg::ST_WAIT: begin
        if (alu_done) begin
          state_d = mhir_pkg::ST_ISSUE;
          case (op_q)
            mhir_pkg::OP_PX: begin
              if (ci_q == 2'd2) begin
                ci_d = 2'd0;
                if (ri_q == 2'd3) begin
                  op_d = mhir_pkg::OP_D;
                  ri_d = 2'd0;
                end else begin
                  ri_d = ri_q + 2'd1;
                end
              end else begin
                ci_d = ci_q + 2'd1;
              end
            end
            mhir_pkg::OP_D: begin
              if (ri_q == 2'd2) begin
                op_d = mhir_pkg::OP_K;
                ri_d = 2'd0;
              end else begin
                ri_d = ri_q + 2'd1;
              end
            end
            mhir_pkg::OP_K: begin
              if (ri_q == 2'd3) begin
                op_d = mhir_pkg::OP_E;
                ri_d = 2'd0;
              end else begin
                ri_d = ri_q + 2'd1;
              end
            end
            mhir_pkg::OP_E: begin
              if (ri_q == 2'd2) begin
                op_d = mhir_pkg::OP_UPD;
                ri_d = 2'd0;
              end else begin
                ri_d = ri_q + 2'd1;
              end
            end
            mhir_pkg::OP_UPD: begin
              if (ri_q == 2'd3) begin
                op_d = mhir_pkg::OP_CM;
                ri_d = 2'd0;
                ci_d = 2'd0;
              end else begin
                ri_d = ri_q + 2'd1;
              end
            end
            mhir_pkg::OP_CM: begin
              op_d = mhir_pkg::OP_CD;
            end
            mhir_pkg::OP_CD: begin
              op_d = mhir_pkg::OP_CM;
              if (ci_q == ri_q) begin
                ci_d = 2'd0;
                if (ri_q == 2'd3) begin
                  op_d = mhir_pkg::OP_BSQ;
                  ri_d = 2'd0;
                end else begin
                  ri_d = ri_q + 2'd1;
                end
              end else begin
                ci_d = ci_q + 2'd1;
              end
            end
            mhir_pkg::OP_BSQ: begin
              if (ri_q == 2'd2) begin
                op_d = mhir_pkg::OP_DONE;
              end else begin
                ri_d = ri_q + 2'd1;
              end
            end
            default: op_d = mhir_pkg::OP_DONE;
          endcase
        end
      end
      mhir_pkg::ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = mhir_pkg::ST_IDLE;
        end
      end
      default: state_d = mhir_pkg::ST_IDLE;
    endcase
  end

  // Control outputs and operand selection.
  always_comb begin
    s_axis_tready = (state_q == mhir_pkg::ST_IDLE);
    alu_req.start = (state_q == mhir_pkg::ST_ISSUE) && (op_q != mhir_pkg::OP_DONE);
    alu_req.div   = (op_q == mhir_pkg::OP_K) || (op_q == mhir_pkg::OP_CD);
    alu_a = '0;
    alu_b = '0;
    case (op_q)
      mhir_pkg::OP_PX: begin
        alu_a = 128'(cov_rd);
        alu_b = 128'(v_q[ci_q]);
      end
      mhir_pkg::OP_D: begin
        alu_a = px_q[ri_q];
        alu_b = 128'(v_q[ri_q]);
      end
      mhir_pkg::OP_K: begin
        alu_a = px_q[ri_q] <<< FRAC_BITS;
        alu_b = d_q;
      end
      mhir_pkg::OP_E: begin
        alu_a = 128'(bias_q[ri_q]);
        alu_b = 128'(v_q[ri_q]);
      end
      mhir_pkg::OP_UPD: begin
        alu_a = 128'(k_q[ri_q]);
        alu_b = 128'(e_q);
      end
      mhir_pkg::OP_CM: begin
        alu_a = px_q[ri_q];
        alu_b = 128'(k_q[ci_q]);
      end
      mhir_pkg::OP_CD: begin
        alu_a = 128'(t_q) <<< FRAC_BITS;
        alu_b = $signed({64'd0, lam});
      end
      mhir_pkg::OP_BSQ: begin
        alu_a = 128'(bias_q[ri_q]);
        alu_b = 128'(bias_q[ri_q]);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  // Writeback sums for the steps that do not store the ALU result as is.
  always_comb begin
    logic signed [63:0] upd_old;
    p_sar   = alu_res >>> FRAC_BITS;
    px_sum  = ((ci_q == 2'd0) ? 128'sd0 : acc_q) + alu_res;
    d_sum   = ((ri_q == 2'd0) ? $signed({64'd0, lam}) : d_q) + (alu_res <<< 1)
              + ((ri_q == 2'd2) ? px_q[3] : 128'sd0);
    e_sum   = ((ri_q == 2'd0) ? ($signed(128'(vsq_q)) <<< FRAC_BITS) : acc_q)
              - (alu_res <<< 1);
    upd_old = (ri_q == 2'd3) ? off_q : bias_q[ri_q];
    upd_sum = 128'(upd_old) + p_sar;
    bsq_sum = ((ri_q == 2'd0) ? 128'sd0 : acc_q) + p_sar;
    bsq_new = mhir_pkg::sat64(bsq_sum);
  end

  mhir_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .busy_o (alu_busy),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mhir_pkg::ST_IDLE;
      op_q    <= mhir_pkg::OP_DONE;
      ri_q    <= '0;
      ci_q    <= '0;
      ax_q    <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      ri_q    <= ri_d;
      ci_q    <= ci_d;
      ax_q    <= ax_d;
    end
  end

  // Estimator state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ff_q  <= mhir_pkg::FF_RESET;
      off_q <= '0;
      bsq_q <= '0;
      fld_q <= '0;
      for (int i = 0; i < 3; i++) begin
        last_q[i] <= '0;
        bias_q[i] <= '0;
      end
      // diagonal slots 0, 2, 5 and 9 start large, the rest at zero
      for (int i = 0; i < 10; i++) begin
        cov_q[i] <= (i == 0 || i == 2 || i == 5 || i == 9) ? COV_RST : 64'd0;
      end
    end else begin
      if (cfg_we_i) begin
        ff_q <= cfg_wdata_i;
      end
      if (state_q == mhir_pkg::ST_ISSUE && op_q == mhir_pkg::OP_DONE) begin
        for (int i = 0; i < 3; i++) begin
          last_q[i] <= v_q[i];
        end
      end
      if (wb_en) begin
        case (op_q)
          mhir_pkg::OP_UPD: begin
            if (ri_q == 2'd3) begin
              off_q <= mhir_pkg::sat64(upd_sum);
            end else begin
              bias_q[ri_q] <= mhir_pkg::sat64(upd_sum);
            end
          end
          mhir_pkg::OP_CD: begin
            cov_q[cov_ix] <= alu_res[63:0];
          end
          mhir_pkg::OP_BSQ: begin
            if (ri_q == 2'd2) begin
              bsq_q <= bsq_new;
              fld_q <= mhir_pkg::sat64(128'(off_q) + 128'(bsq_new));
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Working registers of one update.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < 3; i++) begin
        v_q[i] <= v_in[i];
      end
      dist_q <= '0;
      vsq_q  <= '0;
    end
    if (state_q == mhir_pkg::ST_PREP) begin
      dist_q <= dist_q + DW'($unsigned(dsq));
      vsq_q  <= vsq_q + DW'($unsigned(vsq1));
    end
    if (state_q == mhir_pkg::ST_TAKE) begin
      take_q <= take;
    end
    if (wb_en) begin
      case (op_q)
        mhir_pkg::OP_PX: begin
          acc_q <= px_sum;
          if (ci_q == 2'd2) begin
            px_q[ri_q] <= (px_sum <<< 1) + 128'(cov_rd);
          end
        end
        mhir_pkg::OP_D:   d_q <= d_sum;
        mhir_pkg::OP_K:   k_q[ri_q] <= alu_res[63:0];
        mhir_pkg::OP_E: begin
          acc_q <= e_sum;
          if (ri_q == 2'd2) begin
            e_q <= mhir_pkg::sat64(e_sum - 128'(off_q));
          end
        end
        mhir_pkg::OP_CM:  t_q <= mhir_pkg::sat64(128'(cov_rd) - p_sar);
        mhir_pkg::OP_BSQ: acc_q <= bsq_sum;
        default: ;
      endcase
    end
  end

  // Result beat.
  always_comb begin
    logic signed [63:0] bi, bc, cv, fi;
    logic [16:0] cal;
    logic [15:0] bo;
    logic [31:0] fo;
    out_data = '0;
    for (int i = 0; i < 3; i++) begin
      bi = bias_q[i] >>> FRAC_BITS;
      if (bi < -mhir_pkg::BIAS_LIM) begin
        bc = -mhir_pkg::BIAS_LIM;
      end else if (bi > mhir_pkg::BIAS_LIM) begin
        bc = mhir_pkg::BIAS_LIM;
      end else begin
        bc = bi;
      end
      cv = 64'(v_q[i]) - bc;
      if (cv < -64'sd65536) begin
        cal = 17'h10000;
      end else if (cv > 64'sd65535) begin
        cal = 17'h0FFFF;
      end else begin
        cal = cv[16:0];
      end
      if (bi < -64'sd32768) begin
        bo = 16'h8000;
      end else if (bi > 64'sd32767) begin
        bo = 16'h7FFF;
      end else begin
        bo = bi[15:0];
      end
      out_data[17*i +: 17]      = cal;
      out_data[51 + 16*i +: 16] = bo;
    end
    fi = fld_q >>> FRAC_BITS;
    if (fi < 64'sd0) begin
      fo = 32'd0;
    end else if (fi > mhir_pkg::U32_MAX) begin
      fo = 32'hFFFF_FFFF;
    end else begin
      fo = fi[31:0];
    end
    out_data[130:99] = fo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= out_data;
      m_user_q <= take_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'd0, m_data_q};
  assign m_axis_tuser  = m_user_q;

`ifndef SYNTHESIS
  a_accept_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == mhir_pkg::ST_PREP)
    else $error("sample beat did not start preparation");
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> state_q == mhir_pkg::ST_WAIT)
    else $error("alu result arrived outside the wait state");
  a_issue_idle_alu: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_req.start |-> !alu_busy)
    else $error("step issued while the alu was busy");
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == mhir_pkg::ST_OUT))
    else $error("result beat loaded outside the output state");
`endif

endmodule

### verif/tb_magnetometer_hard_iron_rls.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hard-iron RLS calibration testbench
// Feeds raw magnetometer samples into the calibration block and checks every
// corrected beat against an in-bench fixed-point RLS estimator.
// Samples are mostly noisy points on offset spheres, mixed with raw noise.
// The forgetting factor is swept through several values between phases.
// Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_magnetometer_hard_iron_rls;

  localparam int FB = 24;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [63:0]  q_t;

  typedef struct {
    logic signed [16:0] cal [3];
    logic signed [15:0] bias [3];
    logic [31:0]        fsq;
    logic               acc;
  } cal_beat_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [47:0]   s_axis_tdata = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [135:0]  m_axis_tdata;
  logic [0:0]    m_axis_tuser;
  logic          cfg_we_i = 1'b0;
  logic [24:0]   cfg_wdata_i = '0;

  magnetometer_hard_iron_rls dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // estimator state
  logic [24:0]      lam_reg;
  q_t               cov [10];
  q_t               bias_q [3];
  q_t               w3_q;
  q_t               bsq_q;
  q_t               h2_q;
  longint           last_v [3];

  cal_beat_t        pending_beats [$];
  int               mismatches = 0;
  int               n_sent = 0;
  int               n_taken = 0;
  int               n_checked = 0;

  function automatic q_t sat_q(input wide_t a);
    if (a[127:63] == '0 || a[127:63] == '1) return a[63:0];
    return a[127] ? mhir_pkg::I64_MIN : mhir_pkg::I64_MAX;
  endfunction

  function automatic wide_t mul_sat(input wide_t a, input q_t b);
    logic signed [191:0] p;
    p = a * b;
    if (p[191:127] == '0 || p[191:127] == '1) return p[127:0];
    return p[191] ? {1'b1, 127'd0} : {1'b0, {127{1'b1}}};
  endfunction

  function automatic q_t div_sat(input wide_t n, input wide_t d);
    logic [127:0] un, ud, qt;
    logic         neg;
    if (d == 0) begin
      if (n == 0) return '0;
      return n[127] ? mhir_pkg::I64_MIN : mhir_pkg::I64_MAX;
    end
    neg = n[127] ^ d[127];
    un = n[127] ? -n : n;
    ud = d[127] ? -d : d;
    qt = un / ud;
    if (qt[127:63] != 0) return neg ? mhir_pkg::I64_MIN : mhir_pkg::I64_MAX;
    return neg ? -q_t'(qt[63:0]) : q_t'(qt[63:0]);
  endfunction

  function automatic int tri_ix(input int r, input int c);
    int t;
    if (c > r) begin
      t = r; r = c; c = t;
    end
    return r * (r + 1) / 2 + c;
  endfunction

  function automatic longint clampl(input longint x, input longint lo, input longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic bit beat_differs(input cal_beat_t a, input cal_beat_t b);
    bit diff;
    diff = (a.fsq != b.fsq) || (a.acc != b.acc);
    for (int i = 0; i < 3; i++) begin
      if (a.cal[i] != b.cal[i] || a.bias[i] != b.bias[i]) diff = 1'b1;
    end
    return diff;
  endfunction

  function automatic void reset_estimator();
    lam_reg = mhir_pkg::FF_RESET;
    for (int i = 0; i < 10; i++) cov[i] = '0;
    for (int i = 0; i < 4; i++)
      cov[tri_ix(i, i)] = sat_q(wide_t'(mhir_pkg::COV_INIT) <<< FB);
    for (int i = 0; i < 3; i++) begin
      last_v[i] = 0;
      bias_q[i] = '0;
    end
    w3_q = '0;
    bsq_q = '0;
    h2_q = '0;
  endfunction

  // One RLS step; returns the beat the block should emit for this sample.
  function automatic cal_beat_t rls_update(input logic [47:0] raw);
    cal_beat_t res;
    longint    v [3];
    longint    sq_dist, vsq, b;
    q_t        lam, e, t;
    q_t        k [4];
    wide_t     px [4];
    wide_t     d, acc;
    logic      take;
    lam = q_t'(lam_reg);
    sq_dist = 0;
    vsq = 0;
    for (int i = 0; i < 3; i++) begin
      v[i] = longint'($signed(raw[16*i +: 16]));
      sq_dist += (last_v[i] - v[i]) * (last_v[i] - v[i]);
      vsq += v[i] * v[i];
    end
    take = ((wide_t'(bsq_q) <<< 1) > wide_t'(h2_q)) ||
           ((wide_t'(5 * sq_dist) <<< FB) > (wide_t'(h2_q) <<< 1));
    if (take) begin
      for (int i = 0; i < 4; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += mul_sat(wide_t'(cov[tri_ix(i, j)]), q_t'(v[j]));
        px[i] = (acc <<< 1) + wide_t'(cov[tri_ix(i, 3)]);
      end
      d = wide_t'(lam);
      for (int i = 0; i < 3; i++) d += mul_sat(px[i], q_t'(v[i])) <<< 1;
      d += px[3];
      for (int i = 0; i < 4; i++) k[i] = div_sat(px[i] <<< FB, d);
      acc = wide_t'(vsq) <<< FB;
      for (int i = 0; i < 3; i++) acc -= mul_sat(wide_t'(bias_q[i]), q_t'(v[i])) <<< 1;
      e = sat_q(acc - wide_t'(w3_q));
      for (int i = 0; i < 3; i++)
        bias_q[i] = sat_q(wide_t'(bias_q[i]) + (mul_sat(wide_t'(k[i]), e) >>> FB));
      w3_q = sat_q(wide_t'(w3_q) + (mul_sat(wide_t'(k[3]), e) >>> FB));
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j <= i; j++) begin
          t = sat_q(wide_t'(cov[tri_ix(i, j)]) - (mul_sat(px[i], k[j]) >>> FB));
          cov[tri_ix(i, j)] = div_sat(wide_t'(t) <<< FB, wide_t'(lam));
        end
      end
      acc = 0;
      for (int i = 0; i < 3; i++) acc += mul_sat(wide_t'(bias_q[i]), bias_q[i]) >>> FB;
      bsq_q = sat_q(acc);
      h2_q = sat_q(wide_t'(w3_q) + wide_t'(bsq_q));
      for (int i = 0; i < 3; i++) last_v[i] = v[i];
    end
    for (int i = 0; i < 3; i++) begin
      b = bias_q[i] >>> FB;
      res.cal[i] = 17'(clampl(v[i] - clampl(b, -(64'sd1 <<< 40), 64'sd1 <<< 40), -65536, 65535));
      res.bias[i] = 16'(clampl(b, -32768, 32767));
    end
    res.fsq = 32'(clampl(h2_q >>> FB, 0, 64'sd4294967295));
    res.acc = take;
    return res;
  endfunction

  task automatic send_sample(input logic [47:0] raw);
    // tvalid goes low between beats to keep a single drive per step
    repeat ($urandom_range(0, 17) + 1) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    s_axis_tvalid <= 1'b0;
    pending_beats.push_back(rls_update(raw));
    n_sent++;
    if (pending_beats[$].acc) n_taken++;
  endtask

  // Write the forgetting factor once every expected beat has drained.
  task automatic write_forget(input logic [24:0] val);
    while (pending_beats.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    lam_reg = val;
  endtask

  function automatic logic [15:0] to_s16(input real x);
    if (x > 32767.0) return 16'sh7fff;
    if (x < -32768.0) return 16'sh8000;
    return 16'($rtoi(x));
  endfunction

  // Noisy point on a sphere of radius rad around (bx, by, bz).
  function automatic logic [47:0] sphere_point(input real bx, input real by, input real bz,
                                               input real rad);
    real ux, uy, uz, n;
    ux = real'($urandom_range(0, 2000)) - 1000.0;
    uy = real'($urandom_range(0, 2000)) - 1000.0;
    uz = real'($urandom_range(0, 2000)) - 1000.0;
    n = $sqrt(ux * ux + uy * uy + uz * uz);
    if (n < 1.0) begin
      ux = 1.0;
      n = 1.0;
    end
    return {to_s16(bz + rad * uz / n + real'($urandom_range(0, 8)) - 4.0),
            to_s16(by + rad * uy / n + real'($urandom_range(0, 8)) - 4.0),
            to_s16(bx + rad * ux / n + real'($urandom_range(0, 8)) - 4.0)};
  endfunction

  task automatic test_directed();
    logic [15:0] ext [4];
    ext = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
    send_sample(48'd0);                       // same as reset history: rejected
    send_sample(48'd0);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j += 3)
        send_sample({ext[j], ext[i], ext[3 - i]});
    send_sample({16'sh7fff, 16'sh7fff, 16'sh7fff});
    send_sample({16'sh7fff, 16'sh7fff, 16'sh7fff}); // repeat of the previous sample
    send_sample({16'sh8000, 16'sh8000, 16'sh8000});
    send_sample({16'sd1, 16'sd1, 16'sd1});
    send_sample({16'sd200, 16'sd0, 16'sd0});
    send_sample({16'sd0, 16'sd200, 16'sd0});
    send_sample({16'sd0, 16'sd0, 16'sd200});
    send_sample({16'sh5555, 16'shaaaa, 16'sh5555});
    send_sample({16'shaaaa, 16'sh5555, 16'shaaaa});
  endtask

  task automatic test_sphere_phase(input logic [24:0] lam, input int count,
                                   input int max_rad);
    real bx, by, bz, rad;
    write_forget(lam);
    bx = real'($urandom_range(0, 6000)) - 3000.0;
    by = real'($urandom_range(0, 6000)) - 3000.0;
    bz = real'($urandom_range(0, 6000)) - 3000.0;
    rad = real'($urandom_range(200, max_rad));
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0:       send_sample({$urandom(), 16'($urandom())});
        1:       send_sample(s_axis_tdata);   // repeat the previous sample
        2:       send_sample(sphere_point(bx, by, bz, real'($urandom_range(50, 32767))));
        default: send_sample(sphere_point(bx, by, bz, rad));
      endcase
    end
  endtask

  // checker
  initial begin
    cal_beat_t   got, want;
    logic [135:0] d;
    logic         u;
    wait (rst_ni);
    @(posedge clk_i);
    m_axis_tready <= 1'b1;
    forever begin
      @(negedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        d = m_axis_tdata;
        u = m_axis_tuser[0];
        @(posedge clk_i);
        for (int i = 0; i < 3; i++) begin
          got.cal[i]  = d[17*i +: 17];
          got.bias[i] = d[51 + 16*i +: 16];
        end
        got.fsq = d[130:99];
        got.acc = u;
        n_checked++;
        if (pending_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output beat %0d", n_checked);
        end else begin
          want = pending_beats.pop_front();
          if (beat_differs(got, want)) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("beat %0d: exp cal %0d %0d %0d bias %0d %0d %0d h2 %0d acc %0b",
                       n_checked, want.cal[0], want.cal[1], want.cal[2], want.bias[0],
                       want.bias[1], want.bias[2], want.fsq, want.acc);
              $display("         got cal %0d %0d %0d bias %0d %0d %0d h2 %0d acc %0b",
                       got.cal[0], got.cal[1], got.cal[2], got.bias[0], got.bias[1],
                       got.bias[2], got.fsq, got.acc);
            end
          end
        end
        if ($urandom_range(0, 3) == 0) begin
          m_axis_tready <= 1'b1;                // stretch with no stall
        end else begin
          int stall;
          stall = $urandom_range(0, 17);
          if (stall != 0) begin
            m_axis_tready <= 1'b0;
            repeat (stall) @(posedge clk_i);
            m_axis_tready <= 1'b1;
          end
        end
      end
    end
  end

  initial begin
    reset_estimator();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_sphere_phase(25'd16777216, 200, 20000);
    test_sphere_phase(25'd8388608, 100, 8000);
    test_sphere_phase(25'h1ffffff, 90, 30000);
    test_sphere_phase(25'd0, 60, 5000);
    test_sphere_phase(25'($urandom_range(8388608, 16777216)), 180, 15000);
    test_sphere_phase(mhir_pkg::FF_RESET, 250, 1000);
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("%0d samples sent, %0d updated the estimate, %0d beats checked;",
             n_sent, n_taken, n_checked);
    $display("six forgetting factors used, including zero and the 25-bit maximum");
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #250_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

### sim.f
src/mhir_pkg.sv
src/mhir_alu.sv
src/magnetometer_hard_iron_rls.sv
verif/tb_magnetometer_hard_iron_rls.sv
